>>> design/hjcd_pkg.sv
// Hangul jamo compose/decompose package: word types, code point constants
// and the syllable arithmetic used by hjcd_core.
package hjcd_pkg;

  localparam int CpWidth = 21;

  localparam logic [CpWidth-1:0] SYL_BASE = 21'h00AC00;
  localparam logic [CpWidth-1:0] SYL_LAST = 21'h00D7A3;
  localparam logic [CpWidth-1:0] L_BASE   = 21'h001100;
  localparam logic [CpWidth-1:0] L_LAST   = 21'h001112;
  localparam logic [CpWidth-1:0] V_BASE   = 21'h001161;
  localparam logic [CpWidth-1:0] V_LAST   = 21'h001175;
  localparam logic [CpWidth-1:0] T_BASE   = 21'h0011A7;
  localparam logic [CpWidth-1:0] T_FIRST  = 21'h0011A8;
  localparam logic [CpWidth-1:0] T_LAST   = 21'h0011C2;

  localparam logic REG_DIRECTION = 1'b0;
  localparam logic DIR_COMPOSE   = 1'b0;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [CpWidth-1:0] out_code_point;
    logic               final_item;
  } out_word_t;

  typedef struct packed {
    logic [1:0]           count;
    out_word_t [2:0]      word;
  } hjcd_res_t;

  typedef struct packed {
    logic adv;
    logic eot;
    logic initial_held;
    logic vowel_held;
  } hjcd_stat_t;

  function automatic logic [CpWidth-1:0] hjcd_syl(logic [4:0] l, logic [4:0] v,
                                                  logic [4:0] t);
    logic [8:0]  lv;
    logic [13:0] off;
    lv  = 9'(9'(l) * 9'd21) + 9'(v);
    off = 14'(14'(lv) * 14'd28) + 14'(t);
    return SYL_BASE + 21'(off);
  endfunction

endpackage

>>> design/hjcd_split.sv
// Syllable splitter: turns a syllable offset into leading, vowel and
// trailing indexes by reciprocal multiplies. Uses nothing outside this file.
module hjcd_split (
  input  logic [13:0] s,
  output logic [4:0]  l_idx,
  output logic [4:0]  v_idx,
  output logic [4:0]  t_idx
);

  logic [29:0] p28;
  logic [28:0] pl;
  logic [8:0]  q28;

  assign p28   = 30'(s) * 30'd37450;
  assign pl    = 29'(s) * 29'd28533;
  assign q28   = p28[28:20];
  assign l_idx = pl[28:24];
  assign v_idx = 5'(q28 - 9'(9'(l_idx) * 9'd21));
  assign t_idx = 5'(s - 14'(14'(q28) * 14'd28));

endmodule

>>> design/hjcd_core.sv
// Input register, pending jamo state and the compose/decompose logic.
// Depends on hjcd_pkg and hjcd_split.
module hjcd_core
  import hjcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       direction,
  input  logic       clear,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  input  logic       buf_free,
  output logic       res_valid,
  output hjcd_res_t  res,
  output hjcd_stat_t stat
);

  logic         full;
  in_word_t     held_word;
  logic         initial_held, initial_held_next;
  logic [4:0]   initial_index, initial_index_next;
  logic         vowel_held, vowel_held_next;
  logic [4:0]   vowel_index, vowel_index_next;
  logic [CpWidth-1:0] cp;
  logic         eot;
  logic         is_l, is_v, is_t, in_syl;
  logic         fresh;
  logic [1:0]   n;
  out_word_t [2:0] words;
  logic [4:0]   sp_l, sp_v, sp_t;
  logic         adv;

  assign cp     = held_word.code_point;
  assign eot    = held_word.end_of_text;
  assign is_l   = (cp >= L_BASE) && (cp <= L_LAST);
  assign is_v   = (cp >= V_BASE) && (cp <= V_LAST);
  assign is_t   = (cp >= T_FIRST) && (cp <= T_LAST);
  assign in_syl = (cp >= SYL_BASE) && (cp <= SYL_LAST);

  hjcd_split u_split (
    .s     (14'(cp - SYL_BASE)),
    .l_idx (sp_l),
    .v_idx (sp_v),
    .t_idx (sp_t)
  );

  always_comb begin
    initial_held_next  = initial_held;
    initial_index_next = initial_index;
    vowel_held_next    = vowel_held;
    vowel_index_next   = vowel_index;
    fresh = 1'b0;
    n     = '0;
    words = '0;
    if (direction != DIR_COMPOSE) begin
      if (in_syl) begin
        words[0].out_code_point = L_BASE + 21'(sp_l);
        words[1].out_code_point = V_BASE + 21'(sp_v);
        n = 2'd2;
        if (sp_t != 5'd0) begin
          words[2].out_code_point = T_BASE + 21'(sp_t);
          n = 2'd3;
        end
      end else begin
        words[0].out_code_point = cp;
        n = 2'd1;
      end
    end else begin
      if (initial_held && vowel_held) begin
        if (is_t) begin
          words[n].out_code_point = hjcd_syl(initial_index, vowel_index, 5'(cp - T_BASE));
        end else begin
          words[n].out_code_point = hjcd_syl(initial_index, vowel_index, 5'd0);
          fresh = 1'b1;
        end
        n = n + 2'd1;
        initial_held_next  = 1'b0;
        initial_index_next = '0;
        vowel_held_next    = 1'b0;
        vowel_index_next   = '0;
      end else if (initial_held) begin
        if (is_v) begin
          vowel_held_next  = 1'b1;
          vowel_index_next = 5'(cp - V_BASE);
        end else begin
          words[n].out_code_point = L_BASE + 21'(initial_index);
          n = n + 2'd1;
          initial_held_next  = 1'b0;
          initial_index_next = '0;
          fresh = 1'b1;
        end
      end else begin
        fresh = 1'b1;
      end
      if (fresh) begin
        if (is_l) begin
          initial_held_next  = 1'b1;
          initial_index_next = 5'(cp - L_BASE);
        end else begin
          words[n].out_code_point = cp;
          n = n + 2'd1;
        end
      end
      if (eot) begin
        if (initial_held_next && vowel_held_next) begin
          words[n].out_code_point = hjcd_syl(initial_index_next, vowel_index_next, 5'd0);
          n = n + 2'd1;
        end else if (initial_held_next) begin
          words[n].out_code_point = L_BASE + 21'(initial_index_next);
          n = n + 2'd1;
        end
        initial_held_next  = 1'b0;
        initial_index_next = '0;
        vowel_held_next    = 1'b0;
        vowel_index_next   = '0;
      end
    end
    for (int i = 0; i < 3; i++) begin
      words[i].final_item = eot && (n == 2'(i + 1));
    end
  end

  assign adv       = full && ((n == 2'd0) || buf_free);
  assign in_stall  = full && !adv;
  assign res_valid = adv && (n != 2'd0);
  assign res.count = n;
  assign res.word  = words;

  assign stat.adv          = adv;
  assign stat.eot          = eot;
  assign stat.initial_held = initial_held;
  assign stat.vowel_held   = vowel_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      full <= 1'b1;
    end else if (adv) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      initial_held  <= 1'b0;
      initial_index <= '0;
      vowel_held    <= 1'b0;
      vowel_index   <= '0;
    end else if (adv) begin
      initial_held  <= initial_held_next;
      initial_index <= initial_index_next;
      vowel_held    <= vowel_held_next;
      vowel_index   <= vowel_index_next;
    end
  end

endmodule

>>> design/hjcd_obuf.sv
// Result buffer: holds up to three result words of one item and hands them
// out one per cycle while out_stall is low. Depends on hjcd_pkg.
module hjcd_obuf
  import hjcd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  hjcd_res_t res,
  output logic      free,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  logic [1:0]      cnt;
  out_word_t [2:0] slot;
  logic            take;

  assign out_valid = (cnt != 2'd0);
  assign out_word  = slot[0];
  assign take      = out_valid && !out_stall;
  assign free      = (cnt == 2'd0) || ((cnt == 2'd1) && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= res.count;
    end else if (take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot <= res.word;
    end else if (take) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

endmodule

>>> design/hangul_jamo_compose_decompose_top.sv
// Top level of the Hangul jamo composer/decomposer: register port and
// instances of hjcd_core and hjcd_obuf. Depends on hjcd_pkg.
//
// Input channel: in_valid/in_stall carry one code point word with an
// end-of-text flag. Output channel: out_valid/out_stall carry result words.
// Register 0 (direction) selects compose (0) or decompose (1); writing it
// drops any pending jamo. Write it only while the block is idle.
// A word accepted into the input register is converted there; its results are
// loaded into the result buffer once the buffer is free, and the first of them
// is then shown on out_word.
// One word is taken every cycle while each word yields at most one result
// and out_stall is low. After a word with two or three results, the next
// waits in the input register as the result buffer drains one per cycle.
// When the receiver stalls, the buffer holds its words and in_stall rises
// once the next converted word cannot be placed.
// Reset clears direction to compose, the pending jamo and both channels;
// there is no clearing pass.
module hangul_jamo_compose_decompose_top
  import hjcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_word,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       direction;
  logic       cfg_wr;
  logic       buf_free;
  logic       res_valid;
  hjcd_res_t  res;
  hjcd_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_DIRECTION);
  assign prdata = (paddr[2] == REG_DIRECTION) ? {31'b0, direction} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_COMPOSE;
    end else if (cfg_wr) begin
      direction <= pwdata[0];
    end
  end

  hjcd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .clear     (cfg_wr),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .buf_free  (buf_free),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat)
  );

  hjcd_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .free      (buf_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  a_eot_flush: assert property (@(posedge clk) disable iff (rst)
    stat.adv && stat.eot |=> !stat.initial_held && !stat.vowel_held)
    else $error("pending jamo left after end of text");

  a_vowel_needs_initial: assert property (@(posedge clk) disable iff (rst)
    stat.vowel_held |-> stat.initial_held)
    else $error("vowel held without leading consonant");

  a_decompose_no_state: assert property (@(posedge clk) disable iff (rst)
    direction |-> !stat.initial_held && !stat.vowel_held)
    else $error("pending jamo in decompose mode");
`endif

endmodule
